@@ design/sblt_pkg.sv @@
// ----------------------------------------------------------------------------
// sblt_pkg
// Shared types and constants for the spectrum band level tracker.
// ----------------------------------------------------------------------------
package sblt_pkg;

   localparam int BANDS       = 10;
   localparam int BAND_W      = 4;
   localparam int LOG_STEPS   = 16;
   localparam int STEP_W      = 5;

   localparam logic signed [15:0] LEVEL_FLOOR = -16'sd15360;
   localparam logic signed [15:0] AVG_RESET   = -16'sd11520;
   localparam logic [18:0]        DB_PER_LOG2 = 19'd394566;

   localparam logic [2:0] CSR_AVG_ALPHA  = 3'd0;
   localparam logic [2:0] CSR_PEAK_ALPHA = 3'd1;
   localparam logic [2:0] CSR_INV_FS     = 3'd2;
   localparam logic [2:0] CSR_BIAS       = 3'd3;
   localparam logic [2:0] CSR_SUPPRESS   = 3'd4;

   // Datapath commands issued by the controller
   typedef struct packed {
      logic load;       // capture request, start log
      logic log_step;   // one squaring step of the log
      logic db_calc;    // log2 to dB
      logic avg_calc;   // average update and state write
      logic scale_calc; // scaling and clamp
      logic peak_calc;  // peak update and result capture
      logic cal_calc;   // calibration copy and result capture
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_cal;
   } stat_type;

endpackage

@@ design/sblt_ctrl.sv @@
// ----------------------------------------------------------------------------
// sblt_ctrl
// Sequencer: decode, then log iterations, dB, average, scale and peak steps, or a calibrate copy.
// ----------------------------------------------------------------------------
module sblt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sblt_pkg::stat_type stat,
   input  logic              rsp_free,
   output sblt_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOG, ST_DB, ST_AVG, ST_SCALE, ST_PEAK, ST_WAIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [sblt_pkg::STEP_W-1:0] step_ff, step_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // decode the captured request
            if (!stat.in_range) begin
               state_in = ST_IDLE;
            end else if (stat.is_cal) begin
               if (rsp_free) begin
                  cmd.cal_calc = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               step_in  = '0;
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            cmd.log_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == sblt_pkg::STEP_W'(sblt_pkg::LOG_STEPS - 1)) state_in = ST_DB;
         end
         ST_DB: begin
            cmd.db_calc = 1'b1;
            state_in = ST_AVG;
         end
         ST_AVG: begin
            cmd.avg_calc = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_calc = 1'b1;
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            if (rsp_free) begin
               cmd.peak_calc = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("more than one datapath command");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_tready) else $error("ready after load");
   a_log_len: assert property (@(posedge clock) disable iff (reset)
      cmd.db_calc |-> $past(cmd.log_step)) else $error("dB without log");

endmodule

@@ design/sblt_dpath.sv @@
// ----------------------------------------------------------------------------
// sblt_dpath
// Per-band state, log unit, averaging, scaling and the result register.
// ----------------------------------------------------------------------------
module sblt_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  sblt_pkg::cmd_type            cmd,
   output sblt_pkg::stat_type           stat,
   input  logic [23:0]                  req_tdata,
   input  logic                         csr_valid,
   input  logic [2:0]                   csr_index,
   input  logic [16:0]                  csr_data,
   output logic                         rsp_free,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [71:0]                  rsp_tdata
);

   logic [15:0]        avg_alpha_ff, peak_alpha_ff, inv_fs_ff;
   logic signed [16:0] bias_ff;
   logic signed [15:0] suppress_ff;

   logic signed [15:0] avg_ff [sblt_pkg::BANDS];
   logic [15:0]        peak_ff [sblt_pkg::BANDS];
   logic signed [15:0] cal_ff [sblt_pkg::BANDS];

   logic                        func_ff;
   logic [sblt_pkg::BAND_W-1:0] band_ff;
   logic                        zero_ff;
   logic [3:0]                  exp_ff;
   logic [16:0]                 y_ff;
   logic [15:0]                 frac_ff;
   logic signed [15:0]          db_ff;
   logic signed [15:0]          avg_new_ff;
   logic [15:0]                 scaled_ff;
   logic                        vld_ff;
   logic [71:0]                 data_ff;

   // Request fields
   logic                        f_func;
   logic [sblt_pkg::BAND_W-1:0] f_band;
   logic [15:0]                 f_mag;
   assign f_func = req_tdata[0];
   assign f_band = req_tdata[4:1];
   assign f_mag  = req_tdata[20:5];

   assign stat.in_range = (32'(band_ff) < sblt_pkg::BANDS);
   assign stat.is_cal   = func_ff;
   assign rsp_free      = !vld_ff || rsp_tready;
   assign rsp_tvalid    = vld_ff;
   assign rsp_tdata     = data_ff;

   // Leading one of the magnitude
   logic [3:0]  lead;
   logic [15:0] norm;
   always_comb begin
      lead = '0;
      for (int i = 0; i < 16; i++) begin
         if (f_mag[i]) lead = 4'(i);
      end
      norm = f_mag << (4'd15 - lead);
   end

   // One squaring step
   logic [33:0] sq;
   logic [18:0] sq_s;
   assign sq   = 34'(y_ff) * 34'(y_ff);
   assign sq_s = sq[33:15];

   // log2 magnitude, always <= 0: -L = (16 - e)*65536 - frac
   logic [20:0] neg_l;
   logic [39:0] db_prod;
   logic [16:0] db_mag;
   assign neg_l   = {5'd0, 16'd0} + {(5'd16 - {1'b0, exp_ff}), 16'd0} - 21'(frac_ff);
   assign db_prod = 40'(neg_l) * 40'(sblt_pkg::DB_PER_LOG2);
   assign db_mag  = 17'((db_prod + 40'd8388608) >> 24);

   // Average blend
   logic [sblt_pkg::BAND_W-1:0] bi;
   assign bi = band_ff;
   logic signed [34:0] avg_sum;
   logic signed [15:0] avg_blend;
   assign avg_sum = 35'(avg_ff[bi]) * $signed({19'd0, avg_alpha_ff})
                  + 35'(db_ff) * $signed(18'(18'h10000 - 18'(avg_alpha_ff)))
                  + 35'sd32768;
   assign avg_blend = 16'(avg_sum >>> 16);

   // Scale
   logic signed [16:0] fl_a, fl;
   logic signed [17:0] diff;
   logic signed [35:0] sc_prod;
   logic signed [27:0] sc;
   assign fl_a    = 17'(cal_ff[bi]) + 17'(suppress_ff);
   assign fl      = (17'(avg_new_ff) > fl_a) ? 17'(avg_new_ff) : fl_a;
   assign diff    = 18'(db_ff) - 18'(fl);
   assign sc_prod = 36'(diff) * $signed({20'd0, inv_fs_ff}) + 36'sd128;
   assign sc      = 28'(sc_prod >>> 8) + 28'(bias_ff);

   // Peak blend
   logic [33:0] pk_sum;
   logic [17:0] pk_dec;
   logic [15:0] pk_new;
   assign pk_sum = 34'(peak_ff[bi]) * 34'(peak_alpha_ff)
                 + 34'(scaled_ff) * 34'(17'h10000 - 17'(peak_alpha_ff)) + 34'd32768;
   assign pk_dec = 18'(pk_sum >> 16);
   assign pk_new = (pk_dec > 18'(scaled_ff)) ?
                   ((pk_dec > 18'd65535) ? 16'hFFFF : pk_dec[15:0]) : scaled_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_alpha_ff  <= 16'd62259;
         peak_alpha_ff <= 16'd58982;
         inv_fs_ff     <= 16'd2184;
         bias_ff       <= '0;
         suppress_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            sblt_pkg::CSR_AVG_ALPHA:  avg_alpha_ff  <= csr_data[15:0];
            sblt_pkg::CSR_PEAK_ALPHA: peak_alpha_ff <= csr_data[15:0];
            sblt_pkg::CSR_INV_FS:     inv_fs_ff     <= csr_data[15:0];
            sblt_pkg::CSR_BIAS:       bias_ff       <= csr_data;
            sblt_pkg::CSR_SUPPRESS:   suppress_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Per-band state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sblt_pkg::BANDS; i++) begin
            avg_ff[i]  <= sblt_pkg::AVG_RESET;
            peak_ff[i] <= '0;
            cal_ff[i]  <= '0;
         end
      end else begin
         if (cmd.avg_calc)  avg_ff[bi]  <= avg_blend;
         if (cmd.peak_calc) peak_ff[bi] <= pk_new;
         if (cmd.cal_calc)  cal_ff[bi]  <= avg_ff[bi];
      end
   end

   // Work registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= f_func;
         band_ff <= f_band;
         zero_ff <= (f_mag == '0);
         exp_ff  <= lead;
         y_ff    <= {1'b0, norm};
         frac_ff <= '0;
      end
      if (cmd.log_step) begin
         frac_ff <= {frac_ff[14:0], sq_s[16] | sq_s[17] | sq_s[18]};
         y_ff    <= (sq_s >= 19'd65536) ? 17'(sq_s >> 1) : 17'(sq_s);
      end
      if (cmd.db_calc) begin
         if (zero_ff || (db_mag > 17'd15360)) db_ff <= sblt_pkg::LEVEL_FLOOR;
         else db_ff <= -$signed({1'b0, db_mag[14:0]});
      end
      if (cmd.avg_calc) avg_new_ff <= avg_blend;
      if (cmd.scale_calc) begin
         if (sc < 0) scaled_ff <= '0;
         else if (sc > 28'sd65535) scaled_ff <= 16'hFFFF;
         else scaled_ff <= sc[15:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (cmd.peak_calc || cmd.cal_calc) begin
         vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.peak_calc) begin
         data_ff <= {5'd0, pk_new, scaled_ff, avg_new_ff, db_ff[14:0], band_ff};
      end else if (cmd.cal_calc) begin
         data_ff <= {5'd0, peak_ff[bi], 16'd0, avg_ff[bi], 15'd0, band_ff};
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result lost");
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      (cmd.peak_calc || cmd.cal_calc) |-> rsp_free) else $error("result overrun");
   a_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.avg_calc |-> (db_ff >= sblt_pkg::LEVEL_FLOOR && db_ff <= 0))
      else $error("level out of range");

endmodule

@@ design/spectrum_band_level_tracker_core.sv @@
// A magnitude request passes through decode, 16 log squaring steps, dB,
// average, scale and peak before its result is valid; a calibrate request
// goes from decode to result capture. Both wait in their last step while the
// result register is full and not being read. A new request is accepted only
// once the last one is done; out-of-range requests give no result.
// Reset (synchronous, active high) restores register defaults, sets every
// band average to -45 dB and clears peaks and calibrations at once.
// ----------------------------------------------------------------------------
// spectrum_band_level_tracker_core
// Top level: controller plus datapath with stream request/result channels.
// ----------------------------------------------------------------------------
module spectrum_band_level_tracker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // func[0], band[4:1], magnitude[20:5]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // band_out[3:0], level_db[18:4],
                                   // average_db[34:19], scaled_level[50:35],
                                   // peak_level[66:51]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   sblt_pkg::cmd_type  cmd;
   sblt_pkg::stat_type stat;
   logic               rsp_free;

   assign csr_ready = 1'b1;

   sblt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .rsp_free   (rsp_free),
      .cmd        (cmd)
   );

   sblt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_free   (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
